>>> hdl/swq_pkg.sv
// ----------------------------------------------------------------------------
// swq_pkg
// Shared types and constants for the shortest-wait queue dispatcher.
// ----------------------------------------------------------------------------
package swq_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_SERVERS_DEF = 8;
    localparam int MAX_DEPTH_DEF   = 16;
    localparam int TIME_BITS_DEF   = 20;

    // Field widths of the stream payloads and the registers.
    localparam int SC_W       = 4;
    localparam int QD_W       = 5;
    localparam int DL_W       = 20;
    localparam int SVC_W      = 10;
    localparam int FIN_W      = 20;
    localparam int SRV_W      = 3;
    localparam int IN_DATA_W  = ((SVC_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((FIN_W + 1 + SRV_W + 7) / 8) * 8;

    // Register port.
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 4;

    localparam logic [1:0] REG_SERVER_COUNT = 2'd0;
    localparam logic [1:0] REG_QUEUE_DEPTH  = 2'd1;
    localparam logic [1:0] REG_DEADLINE     = 2'd2;

    localparam logic [SC_W-1:0] SC_RESET = 4'd2;
    localparam logic [QD_W-1:0] QD_RESET = 5'd2;
    localparam logic [DL_W-1:0] DL_RESET = 20'd540;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_QUEUE,
        ST_FINISH
    } t_state;

    // Control of the server table ports.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } t_tbl_ctl;

endpackage

>>> hdl/swq_srv_table.sv
// ----------------------------------------------------------------------------
// swq_srv_table
// Per-server record memory (queue head, next departure, drain time) with
// one registered read port, one write port and per-entry valid bits so that
// a batch start clears every record at once.
// ----------------------------------------------------------------------------
module swq_srv_table #(
    parameter int NUM   = swq_pkg::MAX_SERVERS_DEF,
    parameter int IDX_W = 3,
    parameter int ENT_W = 44
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swq_pkg::t_tbl_ctl   i_ctl,
    input  logic [IDX_W-1:0]    i_rd_addr,
    input  logic [IDX_W-1:0]    i_wr_addr,
    input  logic [ENT_W-1:0]    i_wr_data,
    output logic [ENT_W-1:0]    o_rd_data
);
    import swq_pkg::*;

    logic [ENT_W-1:0] mem_ent [NUM];
    logic [NUM-1:0]   r_valid;
    logic [ENT_W-1:0] r_rd_data;
    logic             r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem_ent[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= mem_ent[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_ctl.clr) begin
                r_valid <= '0;
            end else if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            // A read issued together with a clear already sees the cleared record.
            if (i_ctl.rd_en) begin
                r_rd_ok <= r_valid[i_rd_addr] && !i_ctl.clr;
            end
        end
    end

    // A record never written since the last clear reads as zero.
    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

>>> hdl/shortest_wait_queue_dispatcher.sv
// ----------------------------------------------------------------------------
// shortest_wait_queue_dispatcher
// Assigns jobs to servers with bounded FIFOs: round-robin fill, then the
// server with the earliest next departure.
// ----------------------------------------------------------------------------
// One job is in flight at a time. While the queues are filling, a job goes
// through acceptance, a read of the server record and an update before the
// block is ready again. Once every queue is full, the records of the active
// servers are read one per cycle from the single read port of the server
// table to find the earliest next departure, then the queue state reads and
// writes the service-time memory and the finish state writes the updated
// record and loads the result register. A finished result waits in its own
// register, so a new job is accepted while the previous result is not yet
// taken; the update stalls only if that register is still full when the next
// result is ready. Times saturate at 2^TIME_BITS - 1. No clearing pass runs
// after reset: the user must keep the service-time memory read only at slots
// written in the current batch; the block itself does not enforce this.
module shortest_wait_queue_dispatcher #(
    parameter int MAX_SERVERS = swq_pkg::MAX_SERVERS_DEF,
    parameter int MAX_DEPTH   = swq_pkg::MAX_DEPTH_DEF,
    parameter int TIME_BITS   = swq_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Job stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [swq_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // [9:0] service_time
    input  logic                              s_axis_tuser,   // [0] start_batch
    // Result stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [19:0] finish_time, [20] late, [23:21] server
    output logic [swq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // Register port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swq_pkg::PADDR_W-1:0]       paddr,
    input  logic [swq_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [swq_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import swq_pkg::*;

    localparam int SRV_IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int SLOT_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_W     = $clog2(MAX_SERVERS + 1);
    localparam int RND_W     = $clog2(MAX_DEPTH + 1);
    localparam int TW        = TIME_BITS;
    localparam int DLC_W     = (TIME_BITS > DL_W) ? TIME_BITS : DL_W;
    localparam int ENT_W     = SLOT_W + 2 * TW;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [SC_W-1:0]      r_sc;
    logic [QD_W-1:0]      r_qd;
    logic [DL_W-1:0]      r_dl;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_fill_server, n_fill_server;
    logic [RND_W-1:0]     r_fill_round, n_fill_round;
    logic                 r_fill_done, n_fill_done;
    logic                 r_mode_fill;
    logic [SVC_W-1:0]     r_svc;
    logic [SRV_IDX_W-1:0] r_srv;
    logic [SRV_IDX_W-1:0] r_cmp_idx;
    logic [TW-1:0]        r_ent_drain;
    logic [TW-1:0]        r_ent_nd;
    logic [SLOT_W-1:0]    r_ent_head;
    logic [SVC_W-1:0]     r_qs_rd;
    logic                 r_fwd;
    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [SVC_W-1:0]     mem_qs [MAX_SERVERS][MAX_DEPTH];

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    logic w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc <= SC_RESET;
            r_qd <= QD_RESET;
            r_dl <= DL_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_SERVER_COUNT: r_sc <= pwdata[SC_W-1:0];
                REG_QUEUE_DEPTH:  r_qd <= pwdata[QD_W-1:0];
                REG_DEADLINE:     r_dl <= pwdata[DL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SERVER_COUNT: prdata = APB_DATA_W'(r_sc);
            REG_QUEUE_DEPTH:  prdata = APB_DATA_W'(r_qd);
            REG_DEADLINE:     prdata = APB_DATA_W'(r_dl);
            default:          prdata = '0;
        endcase
    end

    // Effective server count and queue depth, with zero taken as one and clamped to the built size.
    logic [CNT_W-1:0] w_n;
    logic [RND_W-1:0] w_d;

    assign w_n = (r_sc == '0) ? CNT_W'(1) :
                 ((32'(r_sc) > 32'(MAX_SERVERS)) ? CNT_W'(MAX_SERVERS) : CNT_W'(r_sc));
    assign w_d = (r_qd == '0) ? RND_W'(1) :
                 ((32'(r_qd) > 32'(MAX_DEPTH)) ? RND_W'(MAX_DEPTH) : RND_W'(r_qd));

    // ------------------------------------------------------------------
    // Handshake and fill bookkeeping at acceptance
    // ------------------------------------------------------------------
    logic             w_in_acc;
    logic             w_out_free;
    logic [CNT_W-1:0] w_fs0, w_fs1;
    logic [RND_W-1:0] w_fr0, w_fr1;
    logic             w_fd0, w_fd1;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A batch start clears the fill progress before this job is placed; a
    // lowered server count or depth can also close a round or the fill here.
    always_comb begin
        w_fs0 = s_axis_tuser ? '0 : r_fill_server;
        w_fr0 = s_axis_tuser ? '0 : r_fill_round;
        w_fd0 = s_axis_tuser ? 1'b0 : r_fill_done;
        w_fs1 = w_fs0;
        w_fr1 = w_fr0;
        w_fd1 = w_fd0;
        if (!w_fd0) begin
            if (w_fs0 >= w_n) begin
                w_fs1 = '0;
                w_fr1 = w_fr0 + RND_W'(1);
            end
            if (w_fr1 >= w_d) begin
                w_fd1 = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Server table
    // ------------------------------------------------------------------
    t_tbl_ctl             w_tbl_ctl;
    logic [SRV_IDX_W-1:0] w_tbl_rd_addr;
    logic [ENT_W-1:0]     w_tbl_wr_data;
    logic [ENT_W-1:0]     w_tbl_rd_data;
    logic [TW-1:0]        w_rd_drain;
    logic [TW-1:0]        w_rd_nd;
    logic [SLOT_W-1:0]    w_rd_head;

    swq_srv_table #(
        .NUM   (MAX_SERVERS),
        .IDX_W (SRV_IDX_W),
        .ENT_W (ENT_W)
    ) u_srv_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_tbl_ctl),
        .i_rd_addr (w_tbl_rd_addr),
        .i_wr_addr (r_srv),
        .i_wr_data (w_tbl_wr_data),
        .o_rd_data (w_tbl_rd_data)
    );

    assign w_rd_drain = w_tbl_rd_data[TW-1:0];
    assign w_rd_nd    = w_tbl_rd_data[2*TW-1:TW];
    assign w_rd_head  = w_tbl_rd_data[ENT_W-1:2*TW];

    // ------------------------------------------------------------------
    // Datapath values
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  w_cmp_next;
    logic              w_scan_last;
    logic              w_scan_take;
    logic [RND_W-1:0]  w_h_ext, w_hn_ext;
    logic [SLOT_W-1:0] w_h, w_hn;
    logic [SVC_W-1:0]  w_qsv;
    logic [TW:0]       w_drain_sum, w_nd_sum;
    logic [TW-1:0]     w_new_drain, w_new_nd;
    logic              w_late;
    logic              w_finish;

    assign w_cmp_next  = CNT_W'(r_cmp_idx) + CNT_W'(1);
    assign w_scan_last = (w_cmp_next >= w_n);
    assign w_scan_take = (r_cmp_idx == '0) || (w_rd_nd < r_ent_nd);

    // Head slot of the chosen queue, wrapped if the depth was lowered, and
    // the slot that becomes the new head once the old head leaves.
    always_comb begin
        w_h_ext = RND_W'(r_ent_head);
        if (w_h_ext >= w_d) begin
            w_h_ext = '0;
        end
        w_hn_ext = w_h_ext + RND_W'(1);
        if (w_hn_ext >= w_d) begin
            w_hn_ext = '0;
        end
    end

    assign w_h  = w_h_ext[SLOT_W-1:0];
    assign w_hn = w_hn_ext[SLOT_W-1:0];

    // With a depth of one, the new head is the slot just written.
    assign w_qsv = r_fwd ? r_svc : r_qs_rd;

    assign w_drain_sum = {1'b0, r_ent_drain} + (TW+1)'(r_svc);
    assign w_new_drain = w_drain_sum[TW] ? '1 : w_drain_sum[TW-1:0];
    assign w_nd_sum    = {1'b0, r_ent_nd} + (TW+1)'(w_qsv);
    assign w_late      = DLC_W'(r_ent_drain) >= DLC_W'(r_dl);

    always_comb begin
        if (r_mode_fill) begin
            w_new_nd = (r_fill_round == '0) ? w_new_drain : r_ent_nd;
        end else begin
            w_new_nd = w_nd_sum[TW] ? '1 : w_nd_sum[TW-1:0];
        end
    end

    assign w_tbl_wr_data = {r_ent_head, w_new_nd, w_new_drain};
    assign w_finish      = (r_state == ST_FINISH) && w_out_free;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_fd1 ? ST_SCAN : ST_LOAD;
                end
            end
            ST_LOAD:   n_state = ST_FINISH;
            ST_SCAN: begin
                if (w_scan_last) begin
                    n_state = ST_QUEUE;
                end
            end
            ST_QUEUE:  n_state = ST_FINISH;
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs to the memories and fill counters
    // ------------------------------------------------------------------
    logic                 w_qs_wr;
    logic [SLOT_W-1:0]    w_qs_wr_slot;
    logic                 w_qs_rd;

    always_comb begin
        w_tbl_ctl       = '0;
        w_tbl_rd_addr   = w_cmp_next[SRV_IDX_W-1:0];
        w_qs_wr         = 1'b0;
        w_qs_wr_slot    = w_h;
        w_qs_rd         = 1'b0;
        n_fill_server   = r_fill_server;
        n_fill_round    = r_fill_round;
        n_fill_done     = r_fill_done;
        case (r_state)
            ST_IDLE: begin
                w_tbl_ctl.clr   = w_in_acc && s_axis_tuser;
                w_tbl_ctl.rd_en = w_in_acc;
                w_tbl_rd_addr   = w_fd1 ? '0 : w_fs1[SRV_IDX_W-1:0];
                if (w_in_acc) begin
                    n_fill_server = w_fs1;
                    n_fill_round  = w_fr1;
                    n_fill_done   = w_fd1;
                end
            end
            ST_SCAN: begin
                w_tbl_ctl.rd_en = !w_scan_last;
            end
            ST_QUEUE: begin
                w_qs_wr = 1'b1;
                w_qs_rd = 1'b1;
            end
            ST_FINISH: begin
                w_tbl_ctl.wr_en = w_out_free;
                if (r_mode_fill) begin
                    w_qs_wr      = w_out_free;
                    w_qs_wr_slot = r_fill_round[SLOT_W-1:0];
                    if (w_out_free) begin
                        n_fill_server = r_fill_server + CNT_W'(1);
                        if (n_fill_server >= w_n) begin
                            n_fill_server = '0;
                            n_fill_round  = r_fill_round + RND_W'(1);
                            if (n_fill_round >= w_d) begin
                                n_fill_done = 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Service-time memory: one write and one read port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_qs_wr) begin
            mem_qs[r_srv][w_qs_wr_slot] <= r_svc;
        end
        if (w_qs_rd) begin
            r_qs_rd <= mem_qs[r_srv][w_hn];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_fill_server <= '0;
            r_fill_round  <= '0;
            r_fill_done   <= 1'b0;
            r_mode_fill   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_fill_server <= n_fill_server;
            r_fill_round  <= n_fill_round;
            r_fill_done   <= n_fill_done;
            if (w_in_acc) begin
                r_mode_fill <= !w_fd1;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    r_svc     <= s_axis_tdata[SVC_W-1:0];
                    r_srv     <= w_fs1[SRV_IDX_W-1:0];
                    r_cmp_idx <= '0;
                end
            end
            ST_LOAD: begin
                r_ent_drain <= w_rd_drain;
                r_ent_nd    <= w_rd_nd;
                r_ent_head  <= w_rd_head;
            end
            ST_SCAN: begin
                // Strict compare keeps the lowest index on a tie.
                if (w_scan_take) begin
                    r_ent_drain <= w_rd_drain;
                    r_ent_nd    <= w_rd_nd;
                    r_ent_head  <= w_rd_head;
                    r_srv       <= r_cmp_idx;
                end
                if (!w_scan_last) begin
                    r_cmp_idx <= w_cmp_next[SRV_IDX_W-1:0];
                end
            end
            ST_QUEUE: begin
                r_ent_head <= w_hn;
                r_fwd      <= (w_hn == w_h);
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    r_out_data <= OUT_DATA_W'({SRV_W'(r_srv), w_late, FIN_W'(w_new_drain)});
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_finish_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_out_valid && !m_axis_tready) |=> (r_state == ST_FINISH))
        else $error("result update left while the result register was still full");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> r_out_valid)
        else $error("finished job did not load the result register");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != ST_IDLE))
        else $error("accepted job did not start processing");

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_round <= RND_W'(MAX_DEPTH))
        else $error("fill round ran past the queue depth");

endmodule

>>> verif/tb_shortest_wait_queue_dispatcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shortest_wait_queue_dispatcher
// Self-checking bench for the shortest-wait queue dispatcher. A job table of
// edge cases comes first, then phases of register settings with random jobs.
// Every returned beat is compared with a cycle-free dispatch predictor or with
// the typed result of its table row, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_shortest_wait_queue_dispatcher;
    import swq_pkg::*;

    localparam int NSRV = MAX_SERVERS_DEF;
    localparam int NDEP = MAX_DEPTH_DEF;
    localparam logic [FIN_W-1:0] TIME_SAT = '1;
    localparam int JOB_TARGET = 1550;

    typedef struct packed {
        logic [SRV_W-1:0] server;
        logic             late;
        logic [FIN_W-1:0] finish;
    } t_job_result;

    typedef struct {
        bit               start;
        logic [SVC_W-1:0] svc;
        bit               typed;
        t_job_result      res;
    } t_job_row;

    typedef struct {
        logic [SC_W-1:0] sc;
        logic [QD_W-1:0] qd;
        logic [DL_W-1:0] dl;
        bit              fresh;
        int              jobs;
        bit              heavy;
    } t_phase_row;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [9:0] service_time
    logic                  s_axis_tuser = 1'b0; // [0] start_batch
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [19:0] finish_time, [20] late, [23:21] server
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    shortest_wait_queue_dispatcher uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("shortest_wait_queue_dispatcher regression: fail");
        $finish;
    end

    // Predictor copy of the registers and the dispatch state.
    logic [SC_W-1:0]  cfg_servers = SC_RESET;
    logic [QD_W-1:0]  cfg_depth = QD_RESET;
    logic [DL_W-1:0]  cfg_deadline = DL_RESET;
    logic [FIN_W-1:0] drain[NSRV];
    logic [FIN_W-1:0] depart[NSRV];
    logic [SVC_W-1:0] slot_svc[NSRV][NDEP];
    int               head[NSRV];
    int               fill_srv;
    int               fill_rnd;
    bit               fill_done;
    // Server count and depth under which every slot of the batch was written.
    int               batch_n = 2;
    int               batch_d = 2;

    t_job_result      pending_results[$];
    int               mismatches = 0;
    int               jobs_sent = 0;
    int               burst_left = 1;

    function automatic int eff_servers(input logic [SC_W-1:0] v);
        return (v == 0) ? 1 : ((v > NSRV) ? NSRV : int'(v));
    endfunction

    function automatic int eff_depth(input logic [QD_W-1:0] v);
        return (v == 0) ? 1 : ((v > NDEP) ? NDEP : int'(v));
    endfunction

    function automatic logic [FIN_W-1:0] sat_add(input logic [FIN_W-1:0] a,
                                                 input logic [FIN_W-1:0] b);
        logic [FIN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[FIN_W] ? TIME_SAT : s[FIN_W-1:0];
    endfunction

    function automatic void clear_batch();
        for (int s = 0; s < NSRV; s++) begin
            drain[s] = '0;
            depart[s] = '0;
            head[s] = 0;
            for (int k = 0; k < NDEP; k++) slot_svc[s][k] = '0;
        end
        fill_srv = 0;
        fill_rnd = 0;
        fill_done = 1'b0;
    endfunction

    function automatic t_job_result dispatch_job(input bit start,
                                                 input logic [SVC_W-1:0] svc);
        int          n;
        int          d;
        int          srv;
        int          h;
        logic        lt;
        t_job_result r;
        n = eff_servers(cfg_servers);
        d = eff_depth(cfg_depth);
        if (start) begin
            clear_batch();
            batch_n = n;
            batch_d = d;
        end
        // A shrunken server count or depth can end the current round or the fill.
        if (!fill_done) begin
            if (fill_srv >= n) begin
                fill_srv = 0;
                fill_rnd++;
            end
            if (fill_rnd >= d) fill_done = 1'b1;
        end
        if (!fill_done) begin
            srv = fill_srv;
            slot_svc[srv][fill_rnd] = svc;
            lt = drain[srv] >= cfg_deadline;
            drain[srv] = sat_add(drain[srv], FIN_W'(svc));
            if (fill_rnd == 0) depart[srv] = drain[srv];
            fill_srv++;
            if (fill_srv >= n) begin
                fill_srv = 0;
                fill_rnd++;
                if (fill_rnd >= d) fill_done = 1'b1;
            end
        end else begin
            srv = 0;
            for (int i = 1; i < n; i++)
                if (depart[i] < depart[srv]) srv = i;
            h = (head[srv] >= d) ? 0 : head[srv];
            slot_svc[srv][h] = svc;
            h = (h + 1 >= d) ? 0 : h + 1;
            head[srv] = h;
            depart[srv] = sat_add(depart[srv], FIN_W'(slot_svc[srv][h]));
            lt = drain[srv] >= cfg_deadline;
            drain[srv] = sat_add(drain[srv], FIN_W'(svc));
        end
        r.finish = drain[srv];
        r.late = lt;
        r.server = SRV_W'(srv);
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    // One job beat; the sender pauses after each burst.
    task automatic send_job(input bit start, input logic [SVC_W-1:0] svc,
                            input bit typed, input t_job_result typed_res);
        t_job_result r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_DATA_W'(svc);
        s_axis_tuser <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = dispatch_job(start, svc);
        pending_results.push_back(typed ? typed_res : r);
        jobs_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom % 8 == 0) ? $urandom_range(50, 200) : $urandom_range(1, 10);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Write a register, then read it back.
    task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_SERVER_COUNT: cfg_servers = value[SC_W-1:0];
            REG_QUEUE_DEPTH:  cfg_depth = value[QD_W-1:0];
            default:          cfg_deadline = value[DL_W-1:0];
        endcase
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== value)
            note_mismatch($sformatf("register %0d readback: expected %0h, got %0h",
                                    idx, value, prdata));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input t_phase_row ph);
        int               n;
        int               d;
        int               count;
        bit               fresh;
        bit               st;
        logic [SVC_W-1:0] svc;
        wait_idle();
        write_reg(REG_SERVER_COUNT, APB_DATA_W'(ph.sc));
        write_reg(REG_QUEUE_DEPTH, APB_DATA_W'(ph.qd));
        write_reg(REG_DEADLINE, APB_DATA_W'(ph.dl));
        n = eff_servers(ph.sc);
        d = eff_depth(ph.qd);
        // Carrying a batch over is only safe when no never-written slot can be read.
        fresh = ph.fresh || n > batch_n || d > batch_d;
        if (!fresh && !fill_done) begin
            batch_n = n;
            batch_d = d;
        end
        if (ph.jobs > 0)
            count = ph.jobs;
        else
            count = ((fresh || !fill_done) ? n * d : 0) + $urandom_range(8, 30);
        for (int k = 0; k < count; k++) begin
            st = (k == 0) ? fresh : (!ph.heavy && $urandom % 40 == 0);
            if (ph.heavy)
                svc = ($urandom % 8 != 0) ? '1 : SVC_W'($urandom_range(0, 1023));
            else
                case ($urandom % 8)
                    0:       svc = '0;
                    1:       svc = '1;
                    2:       svc = SVC_W'($urandom_range(0, 15));
                    default: svc = SVC_W'($urandom_range(0, 1023));
                endcase
            send_job(st, svc, 1'b0, '0);
        end
    endtask

    // Receiver stall pattern: a randomly chosen mode, picked anew when its span runs out.
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_span = 0;
    int       rx_tick = 0;

    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_span == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_span <= $urandom_range(20, 200);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom % 2);
            RX_SPARSE: m_axis_tready <= ($urandom % 6 == 0);
            default:   m_axis_tready <= rx_tick[0];
        endcase
    end

    t_job_result got;
    t_job_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[FIN_W+SRV_W:0];
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf(
                    "result beat with nothing pending: finish %0d late %0b srv %0d",
                    got.finish, got.late, got.server));
            end else begin
                want = pending_results.pop_front();
                if (got.finish !== want.finish || got.late !== want.late ||
                    got.server !== want.server)
                    note_mismatch($sformatf(
                        {"result: expected finish %0d late %0b srv %0d, ",
                         "got finish %0d late %0b srv %0d"},
                        want.finish, want.late, want.server,
                        got.finish, got.late, got.server));
            end
        end
    end

    // Reset defaults: two servers, depth two, deadline 540.
    t_job_row directed_jobs[20] = '{
        '{1'b1, 10'd1023, 1'b1, '{3'd0, 1'b0, 20'd1023}},
        '{1'b0, 10'd0,    1'b1, '{3'd1, 1'b0, 20'd0}},
        '{1'b0, 10'd1023, 1'b1, '{3'd0, 1'b1, 20'd2046}},
        '{1'b0, 10'd5,    1'b1, '{3'd1, 1'b0, 20'd5}},
        '{1'b0, 10'd7,    1'b0, '0},
        '{1'b0, 10'h2AA,  1'b0, '0},
        '{1'b0, 10'h155,  1'b0, '0},
        '{1'b0, 10'd0,    1'b0, '0},
        '{1'b0, 10'd1023, 1'b0, '0},
        '{1'b1, 10'd10,   1'b1, '{3'd0, 1'b0, 20'd10}},
        // Equal next departures: the lower server index wins.
        '{1'b0, 10'd10,   1'b0, '0},
        '{1'b0, 10'd600,  1'b0, '0},
        '{1'b0, 10'd600,  1'b0, '0},
        '{1'b0, 10'd1,    1'b0, '0},
        '{1'b0, 10'd1,    1'b0, '0},
        '{1'b1, 10'd1023, 1'b1, '{3'd0, 1'b0, 20'd1023}},
        '{1'b0, 10'd1023, 1'b0, '0},
        '{1'b0, 10'd1023, 1'b0, '0},
        '{1'b0, 10'h200,  1'b0, '0},
        '{1'b1, 10'h155,  1'b0, '0}
    };

    // Out-of-range settings, mid-batch changes and the saturating run.
    t_phase_row scripted[9] = '{
        '{4'd0,  5'd0,  20'd0,      1'b1, 0,    1'b0},
        '{4'd15, 5'd31, 20'd1500,   1'b1, 0,    1'b0},
        '{4'd3,  5'd5,  20'd700,    1'b0, 0,    1'b0},
        '{4'd8,  5'd16, 20'd1500,   1'b0, 0,    1'b0},
        '{4'd4,  5'd8,  20'd300,    1'b1, 10,   1'b0},
        '{4'd4,  5'd2,  20'd300,    1'b0, 0,    1'b0},
        '{4'd4,  5'd4,  20'd900,    1'b1, 6,    1'b0},
        '{4'd2,  5'd4,  20'd900,    1'b0, 0,    1'b0},
        '{4'd1,  5'd1,  20'hFFFFF,  1'b1, 1120, 1'b1}
    };

    initial begin
        t_phase_row ph;
        clear_batch();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_jobs[i])
            send_job(directed_jobs[i].start, directed_jobs[i].svc,
                     directed_jobs[i].typed, directed_jobs[i].res);

        foreach (scripted[i]) run_phase(scripted[i]);

        while (jobs_sent < JOB_TARGET) begin
            ph.sc = SC_W'($urandom_range(0, 15));
            ph.qd = ($urandom % 4 == 0) ? QD_W'($urandom_range(0, 31))
                                        : QD_W'($urandom_range(1, 4));
            ph.dl = ($urandom % 4 == 0) ? DL_W'($urandom_range(0, 20'hFFFFF))
                                        : DL_W'($urandom_range(0, 4000));
            ph.fresh = ($urandom % 3 == 0);
            ph.jobs = 0;
            ph.heavy = 1'b0;
            run_phase(ph);
        end

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("shortest_wait_queue_dispatcher regression: pass");
        else
            $display("shortest_wait_queue_dispatcher regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
hdl/swq_pkg.sv
hdl/swq_srv_table.sv
hdl/shortest_wait_queue_dispatcher.sv
verif/tb_shortest_wait_queue_dispatcher.sv
